FILE: hdl/order_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Order table engine assertion macros
// Shared concurrent assertion wrappers on clk; OTE_ASSERT skips reset.
// ----------------------------------------------------------------------------
`ifndef ORDER_TABLE_ENGINE_DEFINES_SVH
`define ORDER_TABLE_ENGINE_DEFINES_SVH

// Check a property on every clock outside reset.
`define OTE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("order table check failed");

// Check a property on every clock, reset included.
`define OTE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("order table check failed in or out of reset");

`endif

FILE: hdl/ote_pkg.sv
// ----------------------------------------------------------------------------
// Order table engine package
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
package ote_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_AMEND  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RC_NONE    = 3'd0,
    RC_SYMBOL  = 3'd1,
    RC_PRICE   = 3'd2,
    RC_QTY     = 3'd3,
    RC_DUP     = 3'd4,
    RC_UNKNOWN = 3'd5,
    RC_FULL    = 3'd6
  } rc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic        active;
    logic [63:0] symbol;
    logic [63:0] price;
    logic [31:0] qty;
  } record_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic read;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/ote_ctrl.sv
// ----------------------------------------------------------------------------
// Order table engine controller
// Sequence one word through key scan, record read and execute.
// ----------------------------------------------------------------------------
module ote_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ote_pkg::dp_stat_t stat,
  output ote_pkg::dp_cmd_t  cmd
);

  ote_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ote_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ote_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ote_pkg::ST_SCAN;
        end
      end
      ote_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ote_pkg::ST_READ;
        end
      end
      ote_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ote_pkg::ST_EXEC;
      end
      ote_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ote_pkg::ST_IDLE;
        end
      end
      default: state_next = ote_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/ote_datapath.sv
// ----------------------------------------------------------------------------
// Order table engine datapath
// Key and record memories, linear key scan, checks and result register.
// ----------------------------------------------------------------------------
module ote_datapath #(
  parameter int TABLE_ENTRIES = ote_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ote_pkg::dp_cmd_t   cmd,
  output ote_pkg::dp_stat_t  stat,
  input  logic [1:0]         operation,
  input  logic [63:0]        order_id,
  input  logic [63:0]        symbol_code,
  input  logic signed [63:0] limit_price,
  input  logic               price_not_finite,
  input  logic [31:0]        order_qty,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        echo_id,
  output logic               was_accepted,
  output logic [2:0]         reject_code,
  output logic [63:0]        found_symbol,
  output logic signed [63:0] found_price,
  output logic [31:0]        found_qty
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  logic [63:0] key_mem [TABLE_ENTRIES];
  ote_pkg::record_t rec_mem [TABLE_ENTRIES];

  ote_pkg::op_t     op_q;
  logic [63:0]      key_q;
  logic [63:0]      sym_q;
  logic [63:0]      price_q;
  logic             nf_q;
  logic [31:0]      qty_q;

  logic [CW-1:0]    used_count;
  logic [CW-1:0]    scan_addr;
  logic             pend;
  logic [AW-1:0]    pend_idx;
  logic [63:0]      rd_key;
  logic             hit;
  logic [AW-1:0]    hit_idx;
  ote_pkg::record_t rec;

  logic             issue;
  logic             price_ok;
  logic             is_active;
  logic             acc;
  ote_pkg::rc_t     rc;
  logic             wr_key;
  logic             wr_rec;
  logic [AW-1:0]    wr_idx;
  ote_pkg::record_t wr_data;

  assign issue = cmd.scan && !hit && (scan_addr < used_count);

  assign stat.scan_done = hit || (!pend && (scan_addr >= used_count));
  assign stat.out_free  = !out_valid || !out_stall;

  // Capture the word and restart the scan.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q    <= ote_pkg::op_t'(operation);
      key_q   <= order_id;
      sym_q   <= symbol_code;
      price_q <= limit_price;
      nf_q    <= price_not_finite;
      qty_q   <= order_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.start) begin
      scan_addr <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (pend && !hit && (rd_key == key_q)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_key   <= key_mem[scan_addr[AW-1:0]];
      pend_idx <= scan_addr[AW-1:0];
    end
    if (pend && !hit && (rd_key == key_q)) begin
      hit_idx <= pend_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rec <= rec_mem[hit_idx];
    end
  end

  // Decide the outcome in the model's check order.
  always_comb begin
    price_ok  = !nf_q && !price_q[63] && (price_q != '0);
    is_active = hit && rec.active;
    acc       = 1'b0;
    rc        = ote_pkg::RC_NONE;
    wr_key    = 1'b0;
    wr_rec    = 1'b0;
    wr_idx    = hit_idx;
    wr_data   = rec;
    unique case (op_q)
      ote_pkg::OP_SUBMIT: begin
        wr_idx  = used_count[AW-1:0];
        wr_data = '{active: 1'b1, symbol: sym_q, price: price_q, qty: qty_q};
        priority if (sym_q == '0) rc = ote_pkg::RC_SYMBOL;
        else if (!price_ok) rc = ote_pkg::RC_PRICE;
        else if (qty_q == '0) rc = ote_pkg::RC_QTY;
        else if (hit) rc = ote_pkg::RC_DUP;
        else if (used_count >= FULL_COUNT) rc = ote_pkg::RC_FULL;
        else begin
          acc    = 1'b1;
          wr_key = 1'b1;
          wr_rec = 1'b1;
        end
      end
      ote_pkg::OP_CANCEL: begin
        wr_data.active = 1'b0;
        if (!is_active) begin
          rc = ote_pkg::RC_UNKNOWN;
        end else begin
          acc    = 1'b1;
          wr_rec = 1'b1;
        end
      end
      ote_pkg::OP_AMEND: begin
        wr_data.price = price_q;
        wr_data.qty   = qty_q;
        priority if (!is_active) rc = ote_pkg::RC_UNKNOWN;
        else if (!price_ok) rc = ote_pkg::RC_PRICE;
        else if (qty_q == '0) rc = ote_pkg::RC_QTY;
        else begin
          acc    = 1'b1;
          wr_rec = 1'b1;
        end
      end
      ote_pkg::OP_QUERY: begin
        if (!is_active) begin
          rc = ote_pkg::RC_UNKNOWN;
        end else begin
          acc = 1'b1;
        end
      end
      default: rc = ote_pkg::RC_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_key) begin
      key_mem[wr_idx] <= key_q;
    end
    if (cmd.exec && wr_rec) begin
      rec_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.exec && wr_key) begin
      used_count <= used_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      echo_id      <= key_q;
      was_accepted <= acc;
      reject_code  <= rc;
      if (op_q == ote_pkg::OP_QUERY && acc) begin
        found_symbol <= rec.symbol;
        found_price  <= rec.price;
        found_qty    <= rec.qty;
      end else begin
        found_symbol <= '0;
        found_price  <= '0;
        found_qty    <= '0;
      end
    end
  end

endmodule

FILE: hdl/order_table_engine.sv
// ----------------------------------------------------------------------------
// Order table engine
// Keyed order table for submit, cancel, amend and query words.
// ----------------------------------------------------------------------------
// One input word is taken at a time and yields one result word. A word is
// captured first, then a linear scan of the key memory reads one stored key
// per cycle until it finds a match or passes the fill count, then the read
// state reads the matching record and the execute state, once the result
// register is free, writes the table and loads the result register. Slots
// fill in order and are never reused, so the fill count stands in for the
// used marks and no clearing pass runs after reset. Once TABLE_ENTRIES keys
// have been stored, further valid submits of new keys are rejected as table
// full. The result register holds a word under stall while the next word is
// scanned.
module order_table_engine #(
  parameter int TABLE_ENTRIES = ote_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [63:0]        order_id,
  input  logic [63:0]        symbol_code,
  input  logic signed [63:0] limit_price,
  input  logic               price_not_finite,
  input  logic [31:0]        order_qty,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        echo_id,
  output logic               was_accepted,
  output logic [2:0]         reject_code,
  output logic [63:0]        found_symbol,
  output logic signed [63:0] found_price,
  output logic [31:0]        found_qty
);

  ote_pkg::dp_cmd_t  cmd;
  ote_pkg::dp_stat_t stat;

  // Sequence each word: capture, scan, read, execute.
  ote_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the table, run the scan and drive the result word.
  ote_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .order_id         (order_id),
    .symbol_code      (symbol_code),
    .limit_price      (limit_price),
    .price_not_finite (price_not_finite),
    .order_qty        (order_qty),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .echo_id          (echo_id),
    .was_accepted     (was_accepted),
    .reject_code      (reject_code),
    .found_symbol     (found_symbol),
    .found_price      (found_price),
    .found_qty        (found_qty)
  );

endmodule

FILE: hdl/ote_checker.sv
// ----------------------------------------------------------------------------
// Order table engine checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "order_table_engine_defines.svh"

module ote_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        was_accepted,
  input logic [2:0]  reject_code,
  input logic [63:0] found_symbol,
  input logic [31:0] found_qty
);

  // Hold a stalled result word.
  `OTE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

  // Accepted words carry no reject code, rejected words carry one.
  `OTE_ASSERT(a_acc_code, out_valid |-> (was_accepted == (reject_code == ote_pkg::RC_NONE)))

  // Found fields only come with an accepted word.
  `OTE_ASSERT(a_found_acc, out_valid && (found_qty != '0 || found_symbol != '0) |-> was_accepted)

  // No new word is taken in the cycle right after one was taken.
  `OTE_ASSERT_ALWAYS(a_one_word, !rst && in_valid && !in_stall |=> in_stall)

endmodule

bind order_table_engine ote_checker u_ote_checker (.*);

FILE: tb/sv/order_table_checker.sv
// ----------------------------------------------------------------------------
// Order table result checker
// Watches both channels of the order table engine. It predicts one reply per
// accepted order word from its own copy of the table and compares replies
// field by field in arrival order.
// ----------------------------------------------------------------------------
module order_table_checker #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] order_id,
  input  logic [63:0] symbol_code,
  input  logic [63:0] limit_price,
  input  logic        price_not_finite,
  input  logic [31:0] order_qty,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] echo_id,
  input  logic        was_accepted,
  input  logic [2:0]  reject_code,
  input  logic [63:0] found_symbol,
  input  logic [63:0] found_price,
  input  logic [31:0] found_qty,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0]  id;
    logic         acc;
    ote_pkg::rc_t rc;
    logic [63:0]  sym;
    logic [63:0]  price;
    logic [31:0]  qty;
  } order_reply_t;

  order_reply_t reply_q[$];
  order_reply_t want;

  // Mirror of the order table: slots fill in order and are never reused.
  int          slot_of[logic [63:0]];
  bit          book_active[TABLE_ENTRIES];
  logic [63:0] book_symbol[TABLE_ENTRIES];
  logic [63:0] book_price[TABLE_ENTRIES];
  logic [31:0] book_qty[TABLE_ENTRIES];
  int          fill_count;

  function automatic bit price_valid(logic [63:0] p, logic nf);
    return !nf && !p[63] && (p != '0);
  endfunction

  function automatic order_reply_t apply_order(ote_pkg::op_t op, logic [63:0] id,
                                               logic [63:0] sym, logic [63:0] p,
                                               logic nf, logic [31:0] q);
    order_reply_t r;
    int s;
    bit live;
    r = '0;
    r.id = id;
    r.rc = ote_pkg::RC_NONE;
    s = slot_of.exists(id) ? slot_of[id] : -1;
    live = (s >= 0) && book_active[s];
    case (op)
      ote_pkg::OP_SUBMIT: begin
        if (sym == '0) r.rc = ote_pkg::RC_SYMBOL;
        else if (!price_valid(p, nf)) r.rc = ote_pkg::RC_PRICE;
        else if (q == '0) r.rc = ote_pkg::RC_QTY;
        else if (s >= 0) r.rc = ote_pkg::RC_DUP;
        else if (fill_count >= TABLE_ENTRIES) r.rc = ote_pkg::RC_FULL;
        else begin
          slot_of[id] = fill_count;
          book_active[fill_count] = 1'b1;
          book_symbol[fill_count] = sym;
          book_price[fill_count] = p;
          book_qty[fill_count] = q;
          fill_count++;
          r.acc = 1'b1;
        end
      end
      ote_pkg::OP_CANCEL: begin
        if (!live) r.rc = ote_pkg::RC_UNKNOWN;
        else begin
          book_active[s] = 1'b0;
          r.acc = 1'b1;
        end
      end
      ote_pkg::OP_AMEND: begin
        if (!live) r.rc = ote_pkg::RC_UNKNOWN;
        else if (!price_valid(p, nf)) r.rc = ote_pkg::RC_PRICE;
        else if (q == '0) r.rc = ote_pkg::RC_QTY;
        else begin
          book_price[s] = p;
          book_qty[s] = q;
          r.acc = 1'b1;
        end
      end
      default: begin
        if (!live) r.rc = ote_pkg::RC_UNKNOWN;
        else begin
          r.acc = 1'b1;
          r.sym = book_symbol[s];
          r.price = book_price[s];
          r.qty = book_qty[s];
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string fname, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, e, a);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      pending = 0;
      checked = 0;
      fill_count = 0;
      reply_q.delete();
      slot_of.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply for id %h, expected none", $time, echo_id);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("echo_id", want.id, echo_id);
          check_field("was_accepted", want.acc, was_accepted);
          check_field("reject_code", want.rc, reject_code);
          check_field("found_symbol", want.sym, found_symbol);
          check_field("found_price", want.price, found_price);
          check_field("found_qty", want.qty, found_qty);
          checked++;
        end
      end
      if (in_valid && !in_stall)
        reply_q.push_back(apply_order(ote_pkg::op_t'(operation), order_id, symbol_code,
                                      limit_price, price_not_finite, order_qty));
      pending = reply_q.size();
    end
  end

endmodule

FILE: tb/sv/order_table_engine_tb.sv
// ----------------------------------------------------------------------------
// Order table engine testbench
// Drives directed and random order words with random gaps and output stalls,
// then fills the table past capacity; the checker predicts and compares replies.
// ----------------------------------------------------------------------------
module order_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ENTRIES    = 1024;
  localparam int  POOL_SIZE  = 48;
  localparam int  RAND_WORDS = 400;
  localparam int  FILL_WORDS = ENTRIES + 60;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [63:0] FILL_BASE = 64'hA500_0000_0000_0000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         operation;
  logic [63:0]        order_id;
  logic [63:0]        symbol_code;
  logic signed [63:0] limit_price;
  logic               price_not_finite;
  logic [31:0]        order_qty;
  logic               out_valid;
  logic               out_stall;
  logic [63:0]        echo_id;
  logic               was_accepted;
  logic [2:0]         reject_code;
  logic [63:0]        found_symbol;
  logic signed [63:0] found_price;
  logic [31:0]        found_qty;

  int fail_count;
  int pending;
  int checked;

  // Idle control: when clear, neither side inserts gaps or stalls.
  bit     idle_on;
  int     stall_left;
  int     stall_len;
  longint cycles;
  logic [63:0] key_pool[POOL_SIZE];

  order_table_engine #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

  order_table_checker #(.TABLE_ENTRIES(ENTRIES)) chk (
    .clk, .rst, .in_valid, .in_stall, .operation, .order_id, .symbol_code,
    .limit_price, .price_not_finite, .order_qty, .out_valid, .out_stall,
    .echo_id, .was_accepted, .reject_code, .found_symbol, .found_price,
    .found_qty, .fail_count, .pending, .checked
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver stall pattern, one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        stall_left = stall_len - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
      $display("** order_table_engine: FAILED **");
      $finish;
    end
  end

  // Present one word after an optional gap, then hold it until accepted.
  // Valid stays high on return so back-to-back words never drop it.
  task automatic send_order(ote_pkg::op_t op, logic [63:0] id, logic [63:0] sym,
                            logic [63:0] price, logic nf, logic [31:0] qty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation        <= op;
    order_id         <= id;
    symbol_code      <= sym;
    limit_price      <= price;
    price_not_finite <= nf;
    order_qty        <= qty;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted reply is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random word: well-formed content on a small key pool, with some noise.
  task automatic send_random();
    ote_pkg::op_t op;
    logic [63:0]  id;
    logic [63:0]  sym;
    logic [63:0]  price;
    logic         nf;
    logic [31:0]  qty;
    int           r;
    op = ote_pkg::op_t'($urandom_range(0, 3));
    id = ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, POOL_SIZE - 1)];
    sym = ($urandom_range(0, 19) == 0) ? 64'd0 : rand64();
    r = $urandom_range(0, 99);
    if (r < 75) price = (rand64() >> 1) | 64'd1;
    else if (r < 85) price = 64'd0;
    else price = rand64();
    nf = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 19);
    qty = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
    send_order(op, id, sym, price, nf, qty);
  endtask

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    operation        = ote_pkg::OP_SUBMIT;
    order_id         = '0;
    symbol_code      = '0;
    limit_price      = '0;
    price_not_finite = 1'b0;
    order_qty        = '0;
    idle_on          = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand64();
    key_pool[0] = 64'd0;
    key_pool[1] = '1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every rejection path but table full, field extremes, cancelled-key handling.
    send_order(ote_pkg::OP_SUBMIT, 64'd10, 64'd0, 64'd5, 1'b0, 32'd1);    // empty symbol
    send_order(ote_pkg::OP_SUBMIT, 64'd10, '1, 64'd0, 1'b0, 32'd1);        // zero price
    send_order(ote_pkg::OP_SUBMIT, 64'd10, '1, 64'h8000_0000_0000_0000, 1'b0, 32'd1);
    send_order(ote_pkg::OP_SUBMIT, 64'd10, '1, 64'd7, 1'b1, 32'd1);        // not finite
    send_order(ote_pkg::OP_SUBMIT, 64'd10, '1, 64'd7, 1'b0, 32'd0);        // zero qty
    send_order(ote_pkg::OP_SUBMIT, 64'd0, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0,
               32'hFFFF_FFFF);
    send_order(ote_pkg::OP_SUBMIT, '1, '1, 64'd1, 1'b0, 32'd1);
    send_order(ote_pkg::OP_SUBMIT, 64'd0, 64'd3, 64'd3, 1'b0, 32'd3);      // duplicate
    send_order(ote_pkg::OP_QUERY, 64'd0, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_QUERY, '1, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_QUERY, 64'd99, 64'd0, 64'd0, 1'b0, 32'd0);      // miss
    send_order(ote_pkg::OP_AMEND, 64'd99, 64'd0, 64'd5, 1'b0, 32'd5);      // unknown
    send_order(ote_pkg::OP_AMEND, 64'd0, 64'd0, -64'sd1, 1'b0, 32'd5);     // bad price
    send_order(ote_pkg::OP_AMEND, 64'd0, 64'd0, 64'd5, 1'b1, 32'd5);
    send_order(ote_pkg::OP_AMEND, 64'd0, 64'd0, 64'd5, 1'b0, 32'd0);       // bad qty
    send_order(ote_pkg::OP_AMEND, 64'd0, 64'd0, 64'd42, 1'b0, 32'd17);
    send_order(ote_pkg::OP_QUERY, 64'd0, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_CANCEL, 64'd99, 64'd0, 64'd0, 1'b0, 32'd0);     // unknown
    send_order(ote_pkg::OP_CANCEL, 64'd0, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_CANCEL, 64'd0, 64'd0, 64'd0, 1'b0, 32'd0);      // cancelled
    send_order(ote_pkg::OP_AMEND, 64'd0, 64'd0, 64'd5, 1'b0, 32'd5);
    send_order(ote_pkg::OP_QUERY, 64'd0, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_SUBMIT, 64'd0, 64'd9, 64'd9, 1'b0, 32'd9);      // reuse of seen key

    // Hold the sender until the engine has answered everything.
    drain();
    repeat (20) @(posedge clk);

    // Random traffic, alternating calm and gappy stretches.
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 200 == 0) idle_on = (i % 400 != 0);
      send_random();
    end
    drain();

    // Fill the table past capacity, then hit the full and duplicate paths.
    idle_on = 1'b0;
    for (int i = 0; i < FILL_WORDS; i++)
      send_order(ote_pkg::OP_SUBMIT, FILL_BASE + i, rand64() | 64'd1,
                 64'd100 + i, 1'b0, 32'd1 + i);
    idle_on = 1'b1;
    send_order(ote_pkg::OP_SUBMIT, FILL_BASE, 64'd1, 64'd1, 1'b0, 32'd1);
    send_order(ote_pkg::OP_QUERY, FILL_BASE + 5, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_CANCEL, FILL_BASE + 5, 64'd0, 64'd0, 1'b0, 32'd0);
    send_order(ote_pkg::OP_SUBMIT, FILL_BASE + 5, 64'd1, 64'd1, 1'b0, 32'd1);
    for (int i = 0; i < 20; i++) send_random();

    drain();
    repeat (ENTRIES + 50) @(posedge clk);

    $display("Checked %0d replies: submit, cancel, amend and query with every reject code,",
             checked);
    $display("random gaps and stalls, and a table filled past its %0d entries.", ENTRIES);
    if (fail_count == 0) begin
      $display("** order_table_engine: PASSED **");
    end else begin
      $display("** order_table_engine: FAILED **");
    end
    $finish;
  end

endmodule

FILE: order_table_engine.f
+incdir+hdl
hdl/ote_pkg.sv
hdl/ote_ctrl.sv
hdl/ote_datapath.sv
hdl/order_table_engine.sv
hdl/ote_checker.sv
tb/sv/order_table_checker.sv
tb/sv/order_table_engine_tb.sv
